### hdl/tsts_pkg.sv
// shared types and constants for the two-segment trailer stack
// no dependencies; used by every module of the block
package tsts_pkg;

  // field widths fixed by the request and result formats
  localparam int unsigned OP_W     = 3;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 41;
  localparam int unsigned CFG_W    = 9;
  localparam int unsigned ALIGN_W  = 2;

  // segment size after reset
  localparam logic [CFG_W-1:0] SEG_SIZE_RESET = 9'd256;

  // opcodes
  localparam logic [OP_W-1:0] OP_PUSH      = 3'd0;
  localparam logic [OP_W-1:0] OP_POP       = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK      = 3'd2;
  localparam logic [OP_W-1:0] OP_DROP_ALL  = 3'd3;
  localparam logic [OP_W-1:0] OP_SAVE      = 3'd4;
  localparam logic [OP_W-1:0] OP_CHECK     = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RESTORE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_MORE    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_TRAILER = 2'd3;

  // alignment targets
  localparam logic [ALIGN_W-1:0] ALIGN_NONE = 2'd0;
  localparam logic [ALIGN_W-1:0] ALIGN_LOW  = 2'd1;
  localparam logic [ALIGN_W-1:0] ALIGN_HIGH = 2'd2;

  // one stored pair, vertex in the low half
  typedef struct packed {
    logic [WORD_W-1:0] index;
    logic [WORD_W-1:0] vertex;
  } pair_t;

  localparam int unsigned PAIR_W = $bits(pair_t);

  // request payload
  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [WORD_W-1:0] push_vertex;
    logic [WORD_W-1:0] push_index;
  } req_t;

  // result payload
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                entry_valid;
    logic [WORD_W-1:0]   out_vertex;
    logic [WORD_W-1:0]   out_index;
    logic                aligned;
    logic                empty_res;
    logic [COUNT_W-1:0]  stored_count;
    logic [WORD_W-1:0]   trailers_now;
  } res_t;

endpackage

### hdl/tsts_bank_ram.sv
// one segment bank: single write port, single registered read port
// depends on tsts_pkg for the pair type
module tsts_bank_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  tsts_pkg::pair_t      wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output tsts_pkg::pair_t      rdata
);

  tsts_pkg::pair_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/tsts_count.sv
// stored entry count: trailers times segment size plus both fills
// registered multiply stage followed by the add; depends on tsts_pkg
module tsts_count #(
  parameter int unsigned FW = 9
) (
  input  logic                           clk,
  input  logic [tsts_pkg::WORD_W-1:0]    trailers,
  input  logic [FW-1:0]                  size,
  input  logic [FW-1:0]                  low_fill,
  input  logic [FW-1:0]                  high_fill,
  output logic [tsts_pkg::COUNT_W-1:0]   count
);

  localparam int unsigned PROD_W = tsts_pkg::WORD_W + FW;

  logic [PROD_W-1:0] prod;
  logic [FW:0]       fill_sum;

  // product and fill sum registered together
  always_ff @(posedge clk) begin
    prod     <= PROD_W'(trailers) * PROD_W'(size);
    fill_sum <= (FW+1)'(low_fill) + (FW+1)'(high_fill);
  end

  // final add, truncated to the count width
  assign count = tsts_pkg::COUNT_W'(prod) + tsts_pkg::COUNT_W'(fill_sum);

endmodule

### hdl/two_segment_trailer_stack_core.sv
// an accepted request passes through the execute, multiply and done states to the
//   output register after the bank read and the registered trailer-count multiply;
//   requests are taken only in idle, so a new one waits until the last is loaded
// reset: synchronous, clears fills, trailer count, bank select, trailers, target
//   and sets segment size to 256; bank contents are not cleared (no clearing pass)
module two_segment_trailer_stack_core #(
  parameter int unsigned SEG_DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  tsts_pkg::req_t               req,
  output logic                         res_valid,
  input  logic                         res_stall,
  output tsts_pkg::res_t               res,
  input  logic                         seg_size_we,
  input  logic [tsts_pkg::CFG_W-1:0]   seg_size_data
);

  localparam int unsigned AW = (SEG_DEPTH > 1) ? $clog2(SEG_DEPTH) : 1;
  localparam int unsigned FW = $clog2(SEG_DEPTH + 1);
  localparam int unsigned CW = (FW > tsts_pkg::CFG_W) ? FW : tsts_pkg::CFG_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_MUL  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] addr;
  } wr_t;

  state_t state, state_next;

  // configuration and stack control state
  logic [tsts_pkg::CFG_W-1:0]   seg_size;
  logic                         low_sel, low_sel_next;
  logic [FW-1:0]                low_fill, low_fill_next;
  logic [FW-1:0]                high_fill, high_fill_next;
  logic [tsts_pkg::WORD_W-1:0]  trailers, trailers_next;
  tsts_pkg::pair_t              last_trailer, last_trailer_next;
  tsts_pkg::pair_t              saved_trailer, saved_trailer_next;
  logic [tsts_pkg::ALIGN_W-1:0] align_target, align_target_next;

  // request held through the operation
  logic [tsts_pkg::OP_W-1:0]    op;
  tsts_pkg::pair_t              pair;

  // partial result from the execute cycle
  logic [tsts_pkg::STATUS_W-1:0] r_status, r_status_next;
  logic                          r_valid, r_valid_next;
  tsts_pkg::pair_t               r_got, r_got_next;
  logic                          r_aligned, r_aligned_next;

  // effective size and read addresses
  logic [CW-1:0]        size_ext;
  logic [FW-1:0]        q;
  logic [FW-1:0]        low_dec, high_dec;
  logic [AW-1:0]        low_raddr, high_raddr;
  logic                 accept, load;

  // bank ports
  wr_t                  lo_wr, hi_wr, a_wr, b_wr;
  logic [AW-1:0]        a_raddr, b_raddr;
  tsts_pkg::pair_t      a_rdata, b_rdata, rd_low, rd_high;
  logic [tsts_pkg::COUNT_W-1:0] count;

  assign accept    = req_valid && (state == S_IDLE);
  assign req_stall = (state != S_IDLE);
  assign load      = (state == S_DONE) && (!res_valid || !res_stall);

  // segment size clamped to 1..SEG_DEPTH
  assign size_ext = CW'(seg_size);
  always_comb begin
    priority if (size_ext == '0) begin
      q = FW'(1);
    end else if (size_ext > CW'(SEG_DEPTH)) begin
      q = FW'(SEG_DEPTH);
    end else begin
      q = FW'(size_ext);
    end
  end

  // tops of both segments, read on every accepted request
  assign low_dec    = low_fill - FW'(1);
  assign high_dec   = high_fill - FW'(1);
  assign low_raddr  = low_dec[AW-1:0];
  assign high_raddr = high_dec[AW-1:0];
  assign a_raddr    = low_sel ? high_raddr : low_raddr;
  assign b_raddr    = low_sel ? low_raddr : high_raddr;
  assign rd_low     = low_sel ? b_rdata : a_rdata;
  assign rd_high    = low_sel ? a_rdata : b_rdata;

  // write routing from segment role to physical bank
  assign a_wr = low_sel ? hi_wr : lo_wr;
  assign b_wr = low_sel ? lo_wr : hi_wr;

  tsts_bank_ram #(
    .DEPTH (SEG_DEPTH),
    .AW    (AW)
  ) u_bank_a (
    .clk   (clk),
    .we    (a_wr.we),
    .waddr (a_wr.addr),
    .wdata (pair),
    .re    (accept),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  tsts_bank_ram #(
    .DEPTH (SEG_DEPTH),
    .AW    (AW)
  ) u_bank_b (
    .clk   (clk),
    .we    (b_wr.we),
    .waddr (b_wr.addr),
    .wdata (pair),
    .re    (accept),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  tsts_count #(
    .FW (FW)
  ) u_count (
    .clk       (clk),
    .trailers  (trailers),
    .size      (q),
    .low_fill  (low_fill),
    .high_fill (high_fill),
    .count     (count)
  );

  // operation decode in the execute cycle
  always_comb begin
    low_sel_next       = low_sel;
    low_fill_next      = low_fill;
    high_fill_next     = high_fill;
    trailers_next      = trailers;
    last_trailer_next  = last_trailer;
    saved_trailer_next = saved_trailer;
    align_target_next  = align_target;
    r_status_next      = tsts_pkg::ST_OK;
    r_valid_next       = 1'b0;
    r_got_next         = '0;
    r_aligned_next     = 1'b0;
    lo_wr              = '0;
    hi_wr              = '0;
    if (state == S_EXEC) begin
      unique case (op)
        tsts_pkg::OP_PUSH: begin
          priority if (low_fill < q) begin
            lo_wr.we      = 1'b1;
            lo_wr.addr    = low_fill[AW-1:0];
            low_fill_next = low_fill + FW'(1);
          end else if (high_fill < q) begin
            hi_wr.we       = 1'b1;
            hi_wr.addr     = high_fill[AW-1:0];
            high_fill_next = high_fill + FW'(1);
          end else begin
            // both full: drop low, old low bank becomes the new high
            last_trailer_next = rd_low;
            if (trailers != '1) begin
              trailers_next = trailers + tsts_pkg::WORD_W'(1);
            end
            low_sel_next   = ~low_sel;
            low_fill_next  = high_fill;
            lo_wr.we       = 1'b1;
            lo_wr.addr     = '0;
            high_fill_next = FW'(1);
          end
        end
        tsts_pkg::OP_POP, tsts_pkg::OP_PEEK: begin
          priority if (high_fill != '0) begin
            r_got_next   = rd_high;
            r_valid_next = 1'b1;
            if (op == tsts_pkg::OP_POP) begin
              high_fill_next = high_dec;
            end
          end else if (low_fill != '0) begin
            r_got_next   = rd_low;
            r_valid_next = 1'b1;
            if (op == tsts_pkg::OP_POP) begin
              low_fill_next = low_dec;
            end
          end else begin
            r_status_next = (trailers != '0) ? tsts_pkg::ST_RESTORE : tsts_pkg::ST_NO_MORE;
          end
        end
        tsts_pkg::OP_DROP_ALL: begin
          low_fill_next  = '0;
          high_fill_next = '0;
          trailers_next  = '0;
        end
        tsts_pkg::OP_SAVE: begin
          if (trailers != '0) begin
            saved_trailer_next = last_trailer;
            align_target_next  = (trailers == tsts_pkg::WORD_W'(1)) ?
                                 tsts_pkg::ALIGN_LOW : tsts_pkg::ALIGN_HIGH;
          end else begin
            r_status_next = tsts_pkg::ST_NO_TRAILER;
          end
        end
        tsts_pkg::OP_CHECK: begin
          priority if (((align_target == tsts_pkg::ALIGN_HIGH) && (high_fill < q)) ||
                       (low_fill < q)) begin
            r_aligned_next = 1'b0;
          end else if (align_target == tsts_pkg::ALIGN_HIGH) begin
            r_aligned_next = (rd_high == saved_trailer);
          end else if (align_target == tsts_pkg::ALIGN_LOW) begin
            r_aligned_next = (rd_low == saved_trailer);
          end else begin
            r_aligned_next = 1'b0;
          end
        end
        default: begin
          r_status_next = tsts_pkg::ST_OK;
        end
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_EXEC;
      S_EXEC: state_next = S_MUL;
      S_MUL:  state_next = S_DONE;
      S_DONE: if (load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control and stack registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      seg_size      <= tsts_pkg::SEG_SIZE_RESET;
      low_sel       <= 1'b0;
      low_fill      <= '0;
      high_fill     <= '0;
      trailers      <= '0;
      last_trailer  <= '0;
      saved_trailer <= '0;
      align_target  <= tsts_pkg::ALIGN_NONE;
    end else begin
      state         <= state_next;
      if (seg_size_we) begin
        seg_size <= seg_size_data;
      end
      low_sel       <= low_sel_next;
      low_fill      <= low_fill_next;
      high_fill     <= high_fill_next;
      trailers      <= trailers_next;
      last_trailer  <= last_trailer_next;
      saved_trailer <= saved_trailer_next;
      align_target  <= align_target_next;
    end
  end

  // request capture and partial result
  always_ff @(posedge clk) begin
    if (accept) begin
      op          <= req.opcode;
      pair.vertex <= req.push_vertex;
      pair.index  <= req.push_index;
    end
    if (state == S_EXEC) begin
      r_status  <= r_status_next;
      r_valid   <= r_valid_next;
      r_got     <= r_got_next;
      r_aligned <= r_aligned_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.status       <= r_status;
      res.entry_valid  <= r_valid;
      res.out_vertex   <= r_got.vertex;
      res.out_index    <= r_got.index;
      res.aligned      <= r_aligned;
      res.empty_res    <= (low_fill == '0) && (high_fill == '0) && (trailers == '0);
      res.stored_count <= count;
      res.trailers_now <= trailers;
    end
  end

endmodule

### tb/two_segment_trailer_stack_core_test.sv
// self-checking bench for the two-segment trailer stack core: a queue-fed driver,
// a clocked monitor and a request-level predictor of the stack, counters and trailers
// depends on hdl/tsts_pkg.sv and hdl/two_segment_trailer_stack_core.sv
module two_segment_trailer_stack_core_test;
  import tsts_pkg::*;

  localparam int unsigned SEG_DEPTH     = 256;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned NUM_PHASES    = 12;
  localparam int unsigned PRINT_CAP     = 100;

  // opcodes the block leaves undecoded
  localparam logic [OP_W-1:0] OP_UNUSED_A = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_B = 3'd7;

  // clock, reset and block ports
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;
  logic seg_size_we = 1'b0;
  logic [CFG_W-1:0] seg_size_data = SEG_SIZE_RESET;

  // stimulus and bookkeeping
  req_t pending_reqs[$];
  res_t awaited_results[$];
  bit req_taken = 1'b0;
  bit no_idle = 1'b0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned items_queued = 0;
  int unsigned requests_taken = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned sizes_written = 0;
  int unsigned entries_returned = 0;
  int unsigned aligned_hits = 0;

  // predictor copy of the stack
  pair_t seg_mem [2][SEG_DEPTH];
  logic lo_is_b = 1'b0;
  int unsigned lo_count = 0;
  int unsigned hi_count = 0;
  logic [WORD_W-1:0] trail_cnt = '0;
  pair_t trail_last = '0;
  pair_t trail_kept = '0;
  logic [ALIGN_W-1:0] target_kept = ALIGN_NONE;
  logic [CFG_W-1:0] seg_size_now = SEG_SIZE_RESET;
  logic [WORD_W-1:0] peak_trailers = '0;

  // payload values reused often enough that equal pairs and alignment hits occur
  logic [WORD_W-1:0] value_pool [4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678,
                                        32'hA5A5_5A5A};

  // random phases: size written, length and share of pushes in percent
  logic [CFG_W-1:0] phase_size [NUM_PHASES] = '{9'd1, 9'd2, 9'd3, 9'd511, 9'd0, 9'd5,
                                                9'd257, 9'd2, 9'd255, 9'd4, 9'd256, 9'd1};
  int unsigned phase_len [NUM_PHASES] = '{45, 45, 45, 560, 45, 45, 40, 45, 40, 45, 40, 45};
  int unsigned phase_push [NUM_PHASES] = '{55, 50, 60, 97, 45, 55, 60, 50, 60, 55, 60, 45};

  two_segment_trailer_stack_core #(
    .SEG_DEPTH(SEG_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res),
    .seg_size_we(seg_size_we),
    .seg_size_data(seg_size_data)
  );

  // 8-unit clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // one mismatch line per call, printing capped but every failure counted
  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= PRINT_CAP)
      $display("mismatch %0d at cycle %0d: %s", fail_count, cycle_count, what);
  endtask

  task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want)
      note_failure($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_span();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // apply one request to the predicted stack and return the result it should give
  function automatic res_t apply_stack_op(input req_t r);
    res_t o;
    pair_t p;
    pair_t got;
    int unsigned q;
    logic [63:0] total;
    o = '0;
    got = '0;
    p.vertex = r.push_vertex;
    p.index = r.push_index;
    // size clamped into 1..SEG_DEPTH
    if (seg_size_now == '0) q = 1;
    else if (seg_size_now > SEG_DEPTH) q = SEG_DEPTH;
    else q = seg_size_now;
    case (r.opcode)
      OP_PUSH: begin
        if (lo_count < q) begin
          seg_mem[lo_is_b][lo_count] = p;
          lo_count++;
        end else if (hi_count < q) begin
          seg_mem[!lo_is_b][hi_count] = p;
          hi_count++;
        end else begin
          // both full: low top becomes the trailer, segments swap
          trail_last = seg_mem[lo_is_b][lo_count - 1];
          if (trail_cnt != '1) trail_cnt++;
          lo_is_b = !lo_is_b;
          lo_count = hi_count;
          seg_mem[!lo_is_b][0] = p;
          hi_count = 1;
        end
      end
      OP_POP, OP_PEEK: begin
        if (hi_count > 0) begin
          got = seg_mem[!lo_is_b][hi_count - 1];
          o.entry_valid = 1'b1;
          if (r.opcode == OP_POP) hi_count--;
        end else if (lo_count > 0) begin
          got = seg_mem[lo_is_b][lo_count - 1];
          o.entry_valid = 1'b1;
          if (r.opcode == OP_POP) lo_count--;
        end else begin
          o.status = (trail_cnt != '0) ? ST_RESTORE : ST_NO_MORE;
        end
      end
      OP_DROP_ALL: begin
        lo_count = 0;
        hi_count = 0;
        trail_cnt = '0;
      end
      OP_SAVE: begin
        if (trail_cnt != '0) begin
          trail_kept = trail_last;
          target_kept = (trail_cnt == 1) ? ALIGN_LOW : ALIGN_HIGH;
        end else begin
          o.status = ST_NO_TRAILER;
        end
      end
      OP_CHECK: begin
        if ((target_kept == ALIGN_HIGH && hi_count < q) || lo_count < q)
          o.aligned = 1'b0;
        else if (target_kept == ALIGN_HIGH)
          o.aligned = (seg_mem[!lo_is_b][hi_count - 1] == trail_kept);
        else if (target_kept == ALIGN_LOW)
          o.aligned = (seg_mem[lo_is_b][lo_count - 1] == trail_kept);
      end
      default: begin
      end
    endcase
    o.out_vertex = got.vertex;
    o.out_index = got.index;
    o.empty_res = (lo_count == 0 && hi_count == 0 && trail_cnt == '0);
    total = 64'(trail_cnt) * 64'(q) + 64'(lo_count) + 64'(hi_count);
    o.stored_count = total[COUNT_W-1:0];
    o.trailers_now = trail_cnt;
    if (trail_cnt > peak_trailers) peak_trailers = trail_cnt;
    return o;
  endfunction

  task automatic queue_item(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] v,
                            input logic [WORD_W-1:0] ix);
    req_t r;
    r.opcode = op;
    r.push_vertex = v;
    r.push_index = ix;
    pending_reqs.push_back(r);
    items_queued++;
  endtask

  // one random request; push-heavy phases leave out drop all
  task automatic queue_random(input int unsigned push_pct);
    int unsigned pick;
    int unsigned kind;
    int unsigned slot;
    logic [OP_W-1:0] op;
    logic [WORD_W-1:0] v;
    logic [WORD_W-1:0] ix;
    pick = $urandom_range(99);
    kind = $urandom_range(99);
    if (pick < push_pct) op = OP_PUSH;
    else if (kind < 40) op = OP_POP;
    else if (kind < 55) op = OP_PEEK;
    else if (kind < 70) op = OP_SAVE;
    else if (kind < 90) op = OP_CHECK;
    else if (kind < 95) op = (push_pct < 90) ? OP_DROP_ALL : OP_POP;
    else op = (kind % 2 == 0) ? OP_UNUSED_A : OP_UNUSED_B;
    if ($urandom_range(9) < 4) begin
      slot = $urandom_range(3);
      v = value_pool[slot];
      ix = value_pool[3 - slot];
    end else begin
      v = $urandom();
      ix = $urandom();
    end
    queue_item(op, v, ix);
  endtask

  // wait until every queued request has its result, then let the pipeline drain
  task automatic settle();
    while (results_seen < items_queued) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_size(input logic [CFG_W-1:0] v);
    seg_size_data <= v;
    seg_size_we <= 1'b1;
    @(negedge clk);
    seg_size_we <= 1'b0;
    sizes_written++;
  endtask

  // request driver: holds a stalled request, otherwise takes the next one after its gap
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_valid && !req_taken) begin
      // stalled: payload held
    end else if (send_gap > 0) begin
      send_gap--;
      req_valid <= 1'b0;
    end else if (pending_reqs.size() > 0) begin
      req <= pending_reqs.pop_front();
      req_valid <= 1'b1;
      send_gap = no_idle ? 0 : idle_span();
    end else begin
      req_valid <= 1'b0;
    end
  end

  // result side stalls
  always @(negedge clk) begin
    if (stall_left > 0) begin
      res_stall <= 1'b1;
      stall_left--;
    end else begin
      res_stall <= 1'b0;
      stall_left = (rst || no_idle) ? 0 : idle_span();
    end
  end

  // monitor: config writes, accepted requests and returned results, all at the rising edge
  always @(posedge clk) begin : monitor
    res_t want;
    req_taken = req_valid && !req_stall;
    if (!rst) cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("run exceeded %0d cycles", CYCLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else if (!rst) begin
      if (seg_size_we) seg_size_now = seg_size_data;
      if (req_valid && !req_stall) begin
        awaited_results.push_back(apply_stack_op(req));
        requests_taken++;
      end
      if (res_valid && !res_stall) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          note_failure("result arrived with nothing outstanding");
        end else begin
          want = awaited_results.pop_front();
          if (want.entry_valid) entries_returned++;
          if (want.aligned) aligned_hits++;
          check_field("status", res.status, want.status);
          check_field("entry_valid", res.entry_valid, want.entry_valid);
          check_field("out_vertex", res.out_vertex, want.out_vertex);
          check_field("out_index", res.out_index, want.out_index);
          check_field("aligned", res.aligned, want.aligned);
          check_field("empty_res", res.empty_res, want.empty_res);
          check_field("stored_count", res.stored_count, want.stored_count);
          check_field("trailers_now", res.trailers_now, want.trailers_now);
        end
      end
    end
  end

  // stimulus sequence
  initial begin
    int unsigned ph;
    int unsigned k;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // empty stack at reset size, undecoded opcodes, field extremes, drop all
    queue_item(OP_POP, '0, '0);
    queue_item(OP_PEEK, '0, '0);
    queue_item(OP_SAVE, '0, '0);
    queue_item(OP_CHECK, '0, '0);
    queue_item(OP_UNUSED_A, '1, '1);
    queue_item(OP_UNUSED_B, '1, '1);
    queue_item(OP_PUSH, '0, '0);
    queue_item(OP_PUSH, '1, '1);
    queue_item(OP_PEEK, '0, '0);
    queue_item(OP_POP, '0, '0);
    queue_item(OP_DROP_ALL, '0, '0);
    settle();

    // size zero acts as one: trailers, both alignment targets, restore needed,
    // save with no trailers after drop all
    set_size('0);
    for (k = 0; k < 3; k++) queue_item(OP_PUSH, value_pool[2], value_pool[3]);
    queue_item(OP_SAVE, '0, '0);
    queue_item(OP_CHECK, '0, '0);
    queue_item(OP_PUSH, value_pool[2], value_pool[3]);
    queue_item(OP_SAVE, '0, '0);
    queue_item(OP_CHECK, '0, '0);
    for (k = 0; k < 3; k++) queue_item(OP_POP, '0, '0);
    queue_item(OP_PEEK, '0, '0);
    queue_item(OP_DROP_ALL, '0, '0);
    queue_item(OP_SAVE, '0, '0);
    queue_item(OP_CHECK, '0, '0);
    settle();

    // random phases over small, large and out-of-range sizes; shrinking happens
    // whenever a phase starts with fills above the new size
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      set_size(phase_size[ph]);
      no_idle = (ph % 3 == 1);
      for (k = 0; k < phase_len[ph]; k++) queue_random(phase_push[ph]);
      settle();
    end

    if (awaited_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", awaited_results.size()));
    $display("%0d requests over %0d size settings, %0d entries returned, %0d aligned answers",
             requests_taken, sizes_written, entries_returned, aligned_hits);
    $display("trailer count peaked at %0d, %0d mismatches", peak_trailers, fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
